FILE: sv/rtc_fields_to_epoch_seconds_unit_assert.svh
// ----------------------------------------------------------------------------
// RTC epoch seconds unit assertion macros
// Clocked concurrent assertion wrappers used by the RTL that asserts.
// ----------------------------------------------------------------------------
`ifndef RTC_FIELDS_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH
`define RTC_FIELDS_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH

// assertion sampled on the rising clock, off during reset
`define RFES_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// assertion sampled on the rising clock, also checked during reset
`define RFES_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/rfes_pkg.sv
// ----------------------------------------------------------------------------
// RTC epoch seconds package
// Shared types, codes, constants and calendar helpers.
// ----------------------------------------------------------------------------
package rfes_pkg;

   localparam int RAW_W      = 8;
   localparam int EPOCH_W    = 38;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_BINARY_MODE  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_HOUR_24_MODE = 1'd1;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EARLY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic [EPOCH_W-1:0] SEC_PER_MIN    = 38'd60;
   localparam logic [EPOCH_W-1:0] SEC_PER_HOUR   = 38'd3600;
   localparam logic [EPOCH_W-1:0] SEC_PER_DAY    = 38'd86400;
   localparam logic [EPOCH_W-1:0] SEC_PER_YEAR   = 38'd31536000;
   localparam logic [EPOCH_W-1:0] SEC_PER_LEAPYR = 38'd31622400;

   localparam logic [6:0] EPOCH_CENTURY = 7'd19;
   localparam logic [6:0] EPOCH_YEAR    = 7'd70;
   localparam logic [6:0] YEAR_LAST     = 7'd99;

   typedef struct packed {
      logic [5:0] second;
      logic [5:0] minute;
      logic [4:0] hour;
      logic [4:0] day;
      logic [3:0] month;
      logic [6:0] year;
      logic [6:0] century;
   } rfes_fields_type;

   typedef struct packed {
      logic idle;
      logic done;
   } rfes_walk_stat_type;

   typedef struct packed {
      logic [EPOCH_W-1:0]  epoch;
      logic [STATUS_W-1:0] status;
   } rfes_result_type;

   function automatic logic leap_of(input logic [6:0] yy, input logic [6:0] cc);
      leap_of = (yy != 7'd0) ? (yy[1:0] == 2'd0) : (cc[1:0] == 2'd0);
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
         4'd2:    month_len = leap ? 5'd29 : 5'd28;
         default: month_len = 5'd0;
      endcase
   endfunction

   function automatic logic [EPOCH_W-1:0] month_secs(input logic [3:0] m, input logic leap);
      case (m) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_secs = 38'd2678400;
         4'd4, 4'd6, 4'd9, 4'd11:                    month_secs = 38'd2592000;
         4'd2:    month_secs = leap ? 38'd2505600 : 38'd2419200;
         default: month_secs = 38'd0;
      endcase
   endfunction

endpackage

FILE: sv/rfes_decode.sv
// ----------------------------------------------------------------------------
// RTC epoch seconds field decoder
// Decodes the raw clock bytes, converts 12-hour time, checks every range and flags years before 1970.
// ----------------------------------------------------------------------------
module rfes_decode
   import rfes_pkg::*;
(
   input  logic [REQ_DATA_W-1:0] raw,
   input  logic                  binary_mode,
   input  logic                  hour_24_mode,
   output rfes_fields_type       fields,
   output logic [STATUS_W-1:0]   status
);

   function automatic logic [8:0] dec(input logic [7:0] b, input logic bin);
      logic       bad_d;
      logic [7:0] v;
      bad_d = 1'b0;
      v     = b;
      if (!bin) begin
         bad_d = (b[7:4] > 4'd9) || (b[3:0] > 4'd9);
         v     = {1'b0, b[7:4], 3'b000} + {3'b000, b[7:4], 1'b0} + {4'b0000, b[3:0]};
      end
      dec = {bad_d, v};
   endfunction

   logic [8:0] d_sec, d_min, d_hour, d_day, d_mon, d_yr, d_cen;
   logic       pm;
   logic       hour_bad;
   logic [4:0] hour;
   logic [4:0] h12_base;
   logic       leap;
   logic [4:0] mlen;
   logic       range_bad;
   logic       early;

   assign pm    = raw[23];
   assign d_sec = dec(raw[7:0],   binary_mode);
   assign d_min = dec(raw[15:8],  binary_mode);
   assign d_day = dec(raw[31:24], binary_mode);
   assign d_mon = dec(raw[39:32], binary_mode);
   assign d_yr  = dec(raw[47:40], binary_mode);
   assign d_cen = dec(raw[55:48], binary_mode);

   always_comb begin
      h12_base = 5'd0;
      if (hour_24_mode) begin
         d_hour   = dec(raw[23:16], binary_mode);
         hour_bad = d_hour[8] || (d_hour[7:0] > 8'd23);
         hour     = d_hour[4:0];
      end else begin
         d_hour   = dec({1'b0, raw[22:16]}, binary_mode);
         hour_bad = d_hour[8] || (d_hour[7:0] == 8'd0) || (d_hour[7:0] > 8'd12);
         h12_base = (d_hour[7:0] == 8'd12) ? 5'd0 : d_hour[4:0];
         hour     = h12_base + (pm ? 5'd12 : 5'd0);
      end
   end

   assign leap = leap_of(d_yr[6:0], d_cen[6:0]);
   assign mlen = month_len(d_mon[3:0], leap);

   assign range_bad = d_sec[8] || d_min[8] || d_day[8] || d_mon[8] || d_yr[8] || d_cen[8]
                   || hour_bad
                   || (d_sec[7:0] > 8'd59) || (d_min[7:0] > 8'd59)
                   || (d_yr[7:0] > 8'd99)  || (d_cen[7:0] > 8'd99)
                   || (d_mon[7:0] < 8'd1)  || (d_mon[7:0] > 8'd12)
                   || (d_day[7:0] < 8'd1)  || (d_day[7:0] > {3'b000, mlen});

   assign early = (d_cen[6:0] < EPOCH_CENTURY)
               || ((d_cen[6:0] == EPOCH_CENTURY) && (d_yr[6:0] < EPOCH_YEAR));

   assign status = range_bad ? ST_RANGE : (early ? ST_EARLY : ST_OK);

   assign fields.second  = d_sec[5:0];
   assign fields.minute  = d_min[5:0];
   assign fields.hour    = hour;
   assign fields.day     = d_day[4:0];
   assign fields.month   = d_mon[3:0];
   assign fields.year    = d_yr[6:0];
   assign fields.century = d_cen[6:0];

endmodule

FILE: sv/rfes_walk.sv
// ----------------------------------------------------------------------------
// RTC epoch seconds calendar walk
// Sequencer that builds epoch seconds with one shared 38-bit adder, one
// year, month, day, hour or minute per cycle.
// ----------------------------------------------------------------------------
module rfes_walk
   import rfes_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                take,
   input  rfes_fields_type     fields,
   input  logic [STATUS_W-1:0] status,
   output rfes_walk_stat_type  stat,
   output rfes_result_type     result
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_YEAR  = 3'd1;
   localparam logic [2:0] S_MONTH = 3'd2;
   localparam logic [2:0] S_DAY   = 3'd3;
   localparam logic [2:0] S_HOUR  = 3'd4;
   localparam logic [2:0] S_MIN   = 3'd5;
   localparam logic [2:0] S_SEC   = 3'd6;
   localparam logic [2:0] S_DONE  = 3'd7;

   logic [2:0]          state_ff, state_in;
   rfes_fields_type     fld_ff, fld_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [EPOCH_W-1:0]  acc_ff, acc_in;
   logic [6:0]          yy_ff, yy_in;
   logic [6:0]          cc_ff, cc_in;
   logic [3:0]          mcnt_ff, mcnt_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [EPOCH_W-1:0]  addend;
   logic [EPOCH_W-1:0]  sum;
   logic                leap_cur;

   assign leap_cur = leap_of(yy_ff, cc_ff);
   assign sum      = acc_ff + addend;

   always_comb begin
      state_in  = state_ff;
      fld_in    = fld_ff;
      status_in = status_ff;
      acc_in    = acc_ff;
      yy_in     = yy_ff;
      cc_in     = cc_ff;
      mcnt_in   = mcnt_ff;
      cnt_in    = cnt_ff;
      addend    = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               fld_in    = fields;
               status_in = status;
               acc_in    = '0;
               yy_in     = EPOCH_YEAR;
               cc_in     = EPOCH_CENTURY;
               mcnt_in   = 4'd1;
               state_in  = (status == ST_OK) ? S_YEAR : S_DONE;
            end
         end
         S_YEAR: begin
            if ((yy_ff == fld_ff.year) && (cc_ff == fld_ff.century)) begin
               state_in = S_MONTH;
            end else begin
               addend = leap_cur ? SEC_PER_LEAPYR : SEC_PER_YEAR;
               acc_in = sum;
               if (yy_ff == YEAR_LAST) begin
                  yy_in = 7'd0;
                  cc_in = cc_ff + 7'd1;
               end else begin
                  yy_in = yy_ff + 7'd1;
               end
            end
         end
         S_MONTH: begin
            if (mcnt_ff == fld_ff.month) begin
               state_in = S_DAY;
               cnt_in   = {1'b0, fld_ff.day - 5'd1};
            end else begin
               addend  = month_secs(mcnt_ff, leap_cur);
               acc_in  = sum;
               mcnt_in = mcnt_ff + 4'd1;
            end
         end
         S_DAY: begin
            if (cnt_ff == 6'd0) begin
               state_in = S_HOUR;
               cnt_in   = {1'b0, fld_ff.hour};
            end else begin
               addend = SEC_PER_DAY;
               acc_in = sum;
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_HOUR: begin
            if (cnt_ff == 6'd0) begin
               state_in = S_MIN;
               cnt_in   = fld_ff.minute;
            end else begin
               addend = SEC_PER_HOUR;
               acc_in = sum;
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_MIN: begin
            if (cnt_ff == 6'd0) begin
               state_in = S_SEC;
            end else begin
               addend = SEC_PER_MIN;
               acc_in = sum;
               cnt_in = cnt_ff - 6'd1;
            end
         end
         S_SEC: begin
            addend   = {{(EPOCH_W-6){1'b0}}, fld_ff.second};
            acc_in   = sum;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      fld_ff    <= fld_in;
      status_ff <= status_in;
      acc_ff    <= acc_in;
      yy_ff     <= yy_in;
      cc_ff     <= cc_in;
      mcnt_ff   <= mcnt_in;
      cnt_ff    <= cnt_in;
   end

   assign stat.idle     = (state_ff == S_IDLE);
   assign stat.done     = (state_ff == S_DONE);
   assign result.epoch  = acc_ff;
   assign result.status = status_ff;

endmodule

FILE: sv/rtc_fields_to_epoch_seconds_unit.sv
// ----------------------------------------------------------------------------
// RTC fields to epoch seconds unit
// Converts one word of raw RTC bytes to Unix epoch seconds with a status.
// ----------------------------------------------------------------------------
// One word at a time: req_tready is high only while the calendar walk is idle.
// The walk sequencer adds one year, month, day, hour or minute per cycle through
// a single 38-bit adder, counting up from 1970, then adds the seconds; words with
// status 1 or 2 skip the walk and finish with zero seconds. The result sits in
// an output register, so the next word is taken while it waits. Write csr_*
// only while no word is in flight.
// ----------------------------------------------------------------------------
`include "rtc_fields_to_epoch_seconds_unit_assert.svh"

module rtc_fields_to_epoch_seconds_unit
   import rfes_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // raw_second, raw_minute, raw_hour, raw_day, raw_month, raw_year, raw_century
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // epoch_seconds, status
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                binary_mode_ff, binary_mode_in;
   logic                hour_24_mode_ff, hour_24_mode_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rfes_result_type     rsp_ff, rsp_in;
   rfes_fields_type     dec_fields;
   logic [STATUS_W-1:0] dec_status;
   rfes_walk_stat_type  walk_stat;
   rfes_result_type     walk_result;
   logic                start;
   logic                take;

   always_comb begin
      binary_mode_in  = binary_mode_ff;
      hour_24_mode_in = hour_24_mode_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_BINARY_MODE:  binary_mode_in  = csr_wdata[0];
            CSR_HOUR_24_MODE: hour_24_mode_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         binary_mode_ff  <= 1'b0;
         hour_24_mode_ff <= 1'b1;
      end else begin
         binary_mode_ff  <= binary_mode_in;
         hour_24_mode_ff <= hour_24_mode_in;
      end
   end

   rfes_decode u_decode (
      .raw          (req_tdata),
      .binary_mode  (binary_mode_ff),
      .hour_24_mode (hour_24_mode_ff),
      .fields       (dec_fields),
      .status       (dec_status)
   );

   assign req_tready = walk_stat.idle;
   assign start      = req_tvalid && req_tready;
   assign take       = walk_stat.done && (!rsp_valid_ff || rsp_tready);

   rfes_walk u_walk (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .take   (take),
      .fields (dec_fields),
      .status (dec_status),
      .stat   (walk_stat),
      .result (walk_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = walk_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.status, rsp_ff.epoch};

   `RFES_ASSERT(a_error_zero, clock, reset, (rsp_valid_ff && (rsp_ff.status != ST_OK)) |-> (rsp_ff.epoch == '0), "error word carries nonzero seconds")
   `RFES_ASSERT(a_status_legal, clock, reset, rsp_valid_ff |-> ((rsp_ff.status == ST_OK) || (rsp_ff.status == ST_EARLY) || (rsp_ff.status == ST_RANGE)), "illegal status code")
   `RFES_ASSERT(a_start_busy, clock, reset, start |=> !walk_stat.idle, "walk stayed idle after accept")
   `RFES_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (walk_stat.idle && !rsp_valid_ff), "walk busy or word pending after reset")

endmodule
